FILE: rtl/core/vector_matrix_mac_saturating_assert.svh
// Assertion macros for the vector by matrix MAC block.
`ifndef VECTOR_MATRIX_MAC_SATURATING_ASSERT_SVH
`define VECTOR_MATRIX_MAC_SATURATING_ASSERT_SVH

// Same-cycle implication, switched off while reset is low.
`define VMM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vmm: implication check failed");

// Next-cycle implication, switched off while reset is low.
`define VMM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vmm: next-cycle check failed");

// Next-cycle implication that also holds through reset.
`define VMM_ASSERT_ALWAYS_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("vmm: reset check failed");

`endif

FILE: rtl/core/vmm_pkg.sv
`timescale 1ns / 1ps

package vmm_pkg;

    // Field widths
    localparam int VALUE_W    = 32;
    localparam int COL_W      = 6;
    localparam int LEN_W      = 11;
    localparam int NCOL_W     = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    // Default storage sizes
    localparam int MAX_LEN_DEF  = 1024;
    localparam int MAX_COLS_DEF = 64;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VEC_LEN       = 2'd0,
        CFG_NUM_COLS      = 2'd1,
        CFG_UNSIGNED_MODE = 2'd2
    } t_cfg_reg;

    // Item function codes
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_MAC  = 1'b1;

    // Effective configuration, shared by front and back
    typedef struct packed {
        logic              restart;
        logic [LEN_W-1:0]  len;
        logic [NCOL_W-1:0] cols;
        logic              unsigned_mode;
    } t_cfg;

    // Classified command handed from front to back
    typedef struct packed {
        logic               is_mac;
        logic [VALUE_W-1:0] value;
        logic [LEN_W-1:0]   addr;
        logic [COL_W-1:0]   col;
        logic               final_row;
        logic               last_col;
    } t_cmd;

endpackage

FILE: rtl/core/vmm_if.sv
`timescale 1ns / 1ps

// Input item channel
interface vmm_in_if;
    import vmm_pkg::*;

    logic               valid;
    logic               ready;
    logic               func;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output func, output value, input ready);
    modport sink   (input valid, input func, input value, output ready);
endinterface

// Result channel
interface vmm_out_if;
    import vmm_pkg::*;

    logic               valid;
    logic               ready;
    logic [COL_W-1:0]   column;
    logic [VALUE_W-1:0] sum_word;
    logic               last;

    modport source (output valid, output column, output sum_word, output last, input ready);
    modport sink   (input valid, input column, input sum_word, input last, output ready);
endinterface

FILE: rtl/core/vmm_queue.sv
`timescale 1ns / 1ps

module vmm_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push_valid,
    output logic          o_push_ready,
    input  vmm_pkg::t_cmd i_push_data,
    output logic          o_pop_valid,
    input  logic          i_pop_ready,
    output vmm_pkg::t_cmd o_pop_data
);
    import vmm_pkg::*;

    localparam int Depth = 4;
    localparam int PtrW  = $clog2(Depth);
    localparam int CntW  = $clog2(Depth + 1);

    t_cmd            r_slot [Depth];
    logic [PtrW-1:0] r_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr;
    logic [CntW-1:0] r_count;
    logic            push;
    logic            pop;

    assign o_push_ready = (r_count != CntW'(Depth));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_slot[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + PtrW'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + PtrW'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + CntW'(1);
            end else if (pop && !push) begin
                r_count <= r_count - CntW'(1);
            end
        end
    end

    // Store the pushed beat
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

FILE: rtl/core/vmm_front.sv
`timescale 1ns / 1ps

module vmm_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  vmm_pkg::t_cfg i_cfg,
    vmm_in_if.sink        i_item,
    output logic          o_cmd_valid,
    input  logic          i_cmd_ready,
    output vmm_pkg::t_cmd o_cmd
);
    import vmm_pkg::*;

    logic [LEN_W-1:0]  r_load_idx;
    logic [LEN_W-1:0]  r_row_idx;
    logic [COL_W-1:0]  r_col_idx;
    logic [LEN_W-1:0]  n_load_idx;
    logic [LEN_W-1:0]  n_row_idx;
    logic [COL_W-1:0]  n_col_idx;
    logic [LEN_W-1:0]  len_m1;
    logic [NCOL_W-1:0] cols_m1;
    logic              accept;
    logic              is_mac;
    logic              final_row;
    logic              last_col;

    assign i_item.ready = i_cmd_ready;
    assign o_cmd_valid  = i_item.valid;
    assign accept       = i_item.valid && i_cmd_ready;
    assign is_mac       = (i_item.func == FUNC_MAC);

    // Classify the beat against the pass position
    assign len_m1    = i_cfg.len - LEN_W'(1);
    assign cols_m1   = i_cfg.cols - NCOL_W'(1);
    assign final_row = (r_row_idx == len_m1);
    assign last_col  = (NCOL_W'(r_col_idx) == cols_m1);

    assign o_cmd.is_mac    = is_mac;
    assign o_cmd.value     = i_item.value;
    assign o_cmd.addr      = is_mac ? r_row_idx : r_load_idx;
    assign o_cmd.col       = r_col_idx;
    assign o_cmd.final_row = final_row;
    assign o_cmd.last_col  = last_col;

    // Step load index, or column then row, with wrap
    always_comb begin
        n_load_idx = r_load_idx;
        n_row_idx  = r_row_idx;
        n_col_idx  = r_col_idx;
        if (!is_mac) begin
            n_load_idx = (r_load_idx == len_m1) ? '0 : r_load_idx + LEN_W'(1);
        end else if (last_col) begin
            n_col_idx = '0;
            n_row_idx = final_row ? '0 : r_row_idx + LEN_W'(1);
        end else begin
            n_col_idx = r_col_idx + COL_W'(1);
        end
    end

    // Hold indices; restart drops them to zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_idx <= '0;
            r_row_idx  <= '0;
            r_col_idx  <= '0;
        end else if (i_cfg.restart) begin
            r_load_idx <= '0;
            r_row_idx  <= '0;
            r_col_idx  <= '0;
        end else if (accept) begin
            r_load_idx <= n_load_idx;
            r_row_idx  <= n_row_idx;
            r_col_idx  <= n_col_idx;
        end
    end

endmodule

FILE: rtl/core/vmm_back.sv
`timescale 1ns / 1ps

module vmm_back #(
    parameter int MAX_LEN  = vmm_pkg::MAX_LEN_DEF,
    parameter int MAX_COLS = vmm_pkg::MAX_COLS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  vmm_pkg::t_cfg i_cfg,
    input  logic          i_cmd_valid,
    output logic          o_cmd_ready,
    input  vmm_pkg::t_cmd i_cmd,
    vmm_out_if.source     o_result
);
    import vmm_pkg::*;

    localparam int AccW   = 2 * VALUE_W;
    localparam int AddrW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int AddrXW = (AddrW > LEN_W) ? AddrW : LEN_W;
    localparam int ColAW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

    typedef enum logic [1:0] {
        B_IDLE,
        B_MUL,
        B_ACC,
        B_OUT
    } t_state;

    logic [VALUE_W-1:0] r_vec_mem [MAX_LEN];
    logic [AccW-1:0]    r_acc_mem [MAX_COLS];
    logic [MAX_COLS-1:0] r_acc_vld;

    t_state             r_state;
    t_cmd               r_cmd;
    logic [VALUE_W-1:0] r_vec_rd;
    logic [VALUE_W-1:0] r_prod;
    logic [AccW-1:0]    r_acc_rd;
    logic               r_acc_rd_vld;
    logic [AccW-1:0]    r_sum;
    logic               r_out_vld;
    logic [COL_W-1:0]   r_out_col;
    logic [VALUE_W-1:0] r_out_sum;
    logic               r_out_last;

    logic [AddrXW-1:0]  cmd_addr_x;
    logic [AddrW-1:0]   cmd_addr;
    logic [ColAW-1:0]   cmd_col;
    logic [ColAW-1:0]   acc_col;
    logic               pop;
    logic               out_free;
    logic [AccW-1:0]    term;
    logic [AccW-1:0]    acc_old;
    logic [AccW-1:0]    acc_new;
    logic [VALUE_W-1:0] clamped;

    assign o_cmd_ready = (r_state == B_IDLE);
    assign pop         = i_cmd_valid && o_cmd_ready;
    assign out_free    = !r_out_vld || o_result.ready;

    assign cmd_addr_x = AddrXW'(i_cmd.addr);
    assign cmd_addr   = cmd_addr_x[AddrW-1:0];
    assign cmd_col    = i_cmd.col[ColAW-1:0];
    assign acc_col    = r_cmd.col[ColAW-1:0];

    // Widen the wrapped product by mode and add into the column total
    assign term    = i_cfg.unsigned_mode ? {{VALUE_W{1'b0}}, r_prod}
                                         : {{VALUE_W{r_prod[VALUE_W-1]}}, r_prod};
    assign acc_old = r_acc_rd_vld ? r_acc_rd : '0;
    assign acc_new = acc_old + term;

    // Clamp the 64-bit total to the 32-bit range of the mode
    always_comb begin
        clamped = r_sum[VALUE_W-1:0];
        if (i_cfg.unsigned_mode) begin
            if (r_sum[AccW-1]) begin
                clamped = '0;
            end else if (|r_sum[AccW-2:VALUE_W]) begin
                clamped = '1;
            end
        end else if (!((&r_sum[AccW-1:VALUE_W-1]) || !(|r_sum[AccW-1:VALUE_W-1]))) begin
            clamped = r_sum[AccW-1] ? {1'b1, {(VALUE_W-1){1'b0}}}
                                    : {1'b0, {(VALUE_W-1){1'b1}}};
        end
    end

    // Vector store: write on load, read on multiply-accumulate
    always_ff @(posedge i_clk) begin
        if (pop && !i_cmd.is_mac) begin
            r_vec_mem[cmd_addr] <= i_cmd.value;
        end
        if (pop && i_cmd.is_mac) begin
            r_vec_rd <= r_vec_mem[cmd_addr];
        end
    end

    // Accumulator store: read on issue, write back after the add except on the final row
    always_ff @(posedge i_clk) begin
        if (pop && i_cmd.is_mac) begin
            r_acc_rd <= r_acc_mem[cmd_col];
        end
        if (r_state == B_ACC && !r_cmd.final_row) begin
            r_acc_mem[acc_col] <= acc_new;
        end
    end

    // Sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= B_IDLE;
            r_acc_vld <= '0;
            r_out_vld <= 1'b0;
        end else begin
            // Drop the taken result beat unless a new one replaces it
            if (o_result.valid && o_result.ready && (r_state != B_OUT)) begin
                r_out_vld <= 1'b0;
            end
            if (i_cfg.restart) begin
                r_acc_vld <= '0;
            end
            case (r_state)
                B_IDLE: begin
                    if (pop && i_cmd.is_mac) begin
                        r_cmd        <= i_cmd;
                        r_acc_rd_vld <= r_acc_vld[cmd_col];
                        r_state      <= B_MUL;
                    end
                end
                B_MUL: begin
                    r_prod  <= r_vec_rd * r_cmd.value;
                    r_state <= B_ACC;
                end
                B_ACC: begin
                    r_sum <= acc_new;
                    if (!i_cfg.restart) begin
                        r_acc_vld[acc_col] <= !r_cmd.final_row;
                    end
                    r_state <= r_cmd.final_row ? B_OUT : B_IDLE;
                end
                B_OUT: begin
                    if (out_free) begin
                        r_out_vld  <= 1'b1;
                        r_out_col  <= r_cmd.col;
                        r_out_sum  <= clamped;
                        r_out_last <= r_cmd.last_col;
                        r_state    <= B_IDLE;
                    end
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
        end
    end

    assign o_result.valid    = r_out_vld;
    assign o_result.column   = r_out_col;
    assign o_result.sum_word = r_out_sum;
    assign o_result.last     = r_out_last;

endmodule

FILE: rtl/core/vector_matrix_mac_saturating.sv
// Vector loads: one beat per cycle sustained while the queue has room, no result.
// Matrix elements: each passes the back sequencer in order (issue read, multiply,
// accumulate); on the final row the clamp stage follows and registers the result once
// the result register is free. The back takes no new beat until it is idle again. A four-entry queue decouples input.
// Reset is synchronous, active low: clears indices, queue, accumulator valid bits and
// the result register; the vector store keeps its contents. No clearing pass is needed.
`timescale 1ns / 1ps

module vector_matrix_mac_saturating #(
    parameter int MAX_LEN  = vmm_pkg::MAX_LEN_DEF,
    parameter int MAX_COLS = vmm_pkg::MAX_COLS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [vmm_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [vmm_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    vmm_in_if.sink                          i_item,
    vmm_out_if.source                       o_result
);
    import vmm_pkg::*;

    localparam int LenMax = (1 << LEN_W) - 1;
    localparam int LenCap = (MAX_LEN > LenMax) ? LenMax : MAX_LEN;

    logic [LEN_W-1:0]  r_vec_len;
    logic [NCOL_W-1:0] r_num_cols;
    logic              r_unsigned_mode;
    logic              cfg_hit;
    t_cfg              cfg;
    t_cmd              front_cmd;
    t_cmd              back_cmd;
    logic              front_valid;
    logic              front_ready;
    logic              back_valid;
    logic              back_ready;

    // Register writes; any known index restarts the pass
    assign cfg_hit = i_cfg_we && ((i_cfg_idx == CFG_VEC_LEN) || (i_cfg_idx == CFG_NUM_COLS)
                               || (i_cfg_idx == CFG_UNSIGNED_MODE));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vec_len       <= LEN_W'(1);
            r_num_cols      <= NCOL_W'(1);
            r_unsigned_mode <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_VEC_LEN:       r_vec_len       <= i_cfg_data[LEN_W-1:0];
                CFG_NUM_COLS:      r_num_cols      <= i_cfg_data[NCOL_W-1:0];
                CFG_UNSIGNED_MODE: r_unsigned_mode <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Clamp lengths into the supported range
    assign cfg.restart       = cfg_hit;
    assign cfg.len           = (r_vec_len == '0)               ? LEN_W'(1) :
                               (r_vec_len > LEN_W'(LenCap))    ? LEN_W'(LenCap) : r_vec_len;
    assign cfg.cols          = (r_num_cols == '0)              ? NCOL_W'(1) :
                               (r_num_cols > NCOL_W'(MAX_COLS)) ? NCOL_W'(MAX_COLS) : r_num_cols;
    assign cfg.unsigned_mode = r_unsigned_mode;

    vmm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_item      (i_item),
        .o_cmd_valid (front_valid),
        .i_cmd_ready (front_ready),
        .o_cmd       (front_cmd)
    );

    vmm_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .o_push_ready (front_ready),
        .i_push_data  (front_cmd),
        .o_pop_valid  (back_valid),
        .i_pop_ready  (back_ready),
        .o_pop_data   (back_cmd)
    );

    vmm_back #(
        .MAX_LEN  (MAX_LEN),
        .MAX_COLS (MAX_COLS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd_valid (back_valid),
        .o_cmd_ready (back_ready),
        .i_cmd       (back_cmd),
        .o_result    (o_result)
    );

endmodule

FILE: rtl/core/vector_matrix_mac_saturating_chk.sv
`timescale 1ns / 1ps
`include "vector_matrix_mac_saturating_assert.svh"

module vector_matrix_mac_saturating_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [vmm_pkg::COL_W-1:0]     i_out_column,
    input logic [vmm_pkg::VALUE_W-1:0]   i_out_sum_word,
    input logic                          i_out_last
);
    import vmm_pkg::*;

    // A stalled result beat holds its payload
    `VMM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_column) && $stable(i_out_sum_word) && $stable(i_out_last))

    // Reset empties the result register
    `VMM_ASSERT_ALWAYS_NEXT(a_reset_empties_out, i_clk, !i_rst_n, !i_out_valid)

    // A result needs the full pipeline run out of reset
    `VMM_ASSERT_IMPL(a_out_after_run, i_clk, i_rst_n, $rose(i_out_valid), $past(i_rst_n, 1) && $past(i_rst_n, 2) && $past(i_rst_n, 3) && $past(i_rst_n, 4))

endmodule

bind vector_matrix_mac_saturating vector_matrix_mac_saturating_chk u_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_result.valid),
    .i_out_ready    (o_result.ready),
    .i_out_column   (o_result.column),
    .i_out_sum_word (o_result.sum_word),
    .i_out_last     (o_result.last)
);
